// ===== hdl/imc_pkg.sv =====
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types and codes of the IPv4 to MAC address cache: beat layouts of
// the request and response channels, the scan token and the write bus.
// ----------------------------------------------------------------------------
`default_nettype none

package imc_pkg;

   localparam int IpWidth  = 32;
   localparam int MacWidth = 48;

   // request kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_LEARN  = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [IpWidth-1:0]  ip_addr;
      logic [MacWidth-1:0] mac_addr;
   } imc_req_type;

   typedef struct packed {
      logic                hit;
      logic [MacWidth-1:0] found_mac;
   } imc_rsp_type;

   // token that walks the row of cells, one cell per cycle while the row is not held
   typedef struct packed {
      logic                active;
      logic                kind;
      logic [IpWidth-1:0]  ip_addr;
      logic [MacWidth-1:0] mac_addr;
      logic                hit;
      logic [MacWidth-1:0] found_mac;
      logic                free_seen;
   } imc_scan_type;

   // entry write, broadcast to all cells
   typedef struct packed {
      logic                en;
      logic [IpWidth-1:0]  ip_addr;
      logic [MacWidth-1:0] mac_addr;
   } imc_wr_type;

endpackage

`default_nettype wire

// ===== hdl/imc_cell.sv =====
// ----------------------------------------------------------------------------
// imc_cell
// One cache slot. Holds valid, key and MAC, checks the passing scan token
// against its slot and hands the token to the next cell through its token register when the row advances.
// ----------------------------------------------------------------------------
`default_nettype none

module imc_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 adv,
   input  imc_pkg::imc_scan_type scan_in,
   input  wire [IDX_W-1:0]     match_idx_in,
   input  wire [IDX_W-1:0]     free_idx_in,
   output imc_pkg::imc_scan_type scan_out,
   output logic [IDX_W-1:0]    match_idx_out,
   output logic [IDX_W-1:0]    free_idx_out,
   input  imc_pkg::imc_wr_type wr,
   input  wire [IDX_W-1:0]     wr_idx
);

   localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

   logic                           valid_ff;
   logic [imc_pkg::IpWidth-1:0]    ip_ff;
   logic [imc_pkg::MacWidth-1:0]   mac_ff;

   imc_pkg::imc_scan_type          scan_ff, scan_in_nx;
   logic [IDX_W-1:0]               match_idx_ff, match_idx_in_nx;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in_nx;

   logic match;
   logic wr_here;

   assign match   = valid_ff && (ip_ff == scan_in.ip_addr);
   assign wr_here = wr.en && (wr_idx == MyIdx);

   always_comb begin
      scan_in_nx      = scan_in;
      match_idx_in_nx = match_idx_in;
      free_idx_in_nx  = free_idx_in;
      // lowest matching slot wins
      if (!scan_in.hit && match) begin
         scan_in_nx.hit       = 1'b1;
         scan_in_nx.found_mac = mac_ff;
         match_idx_in_nx      = MyIdx;
      end
      if (!scan_in.free_seen && !valid_ff) begin
         scan_in_nx.free_seen = 1'b1;
         free_idx_in_nx       = MyIdx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         scan_ff.active <= 1'b0;
      end else begin
         if (wr_here) begin
            valid_ff <= 1'b1;
         end
         if (adv) begin
            scan_ff.active <= scan_in_nx.active;
         end
      end
      // slot contents and token payload carry no reset
      if (wr_here) begin
         ip_ff  <= wr.ip_addr;
         mac_ff <= wr.mac_addr;
      end
      if (adv) begin
         scan_ff.kind      <= scan_in_nx.kind;
         scan_ff.ip_addr   <= scan_in_nx.ip_addr;
         scan_ff.mac_addr  <= scan_in_nx.mac_addr;
         scan_ff.hit       <= scan_in_nx.hit;
         scan_ff.found_mac <= scan_in_nx.found_mac;
         scan_ff.free_seen <= scan_in_nx.free_seen;
         match_idx_ff      <= match_idx_in_nx;
         free_idx_ff       <= free_idx_in_nx;
      end
   end

   assign scan_out      = scan_ff;
   assign match_idx_out = match_idx_ff;
   assign free_idx_out  = free_idx_ff;

endmodule

`default_nettype wire

// ===== hdl/ip_to_mac_cache.sv =====
// ----------------------------------------------------------------------------
// ip_to_mac_cache
// Fully associative IPv4 to MAC cache with lowest-free fill and round-robin
// replacement, built as a row of slot cells.
// ----------------------------------------------------------------------------
// An accepted request beat enters the first cell and walks the row one cell
// per cycle; each cell checks its own slot and passes the token on. When
// the token leaves the last cell, a learn writes the matching slot, else the
// lowest free slot, else the round-robin victim, and a lookup loads the
// response register (hit plus MAC, MAC zero on a miss). One request is in
// the row at a time, so the next request is accepted only after the token
// has left the last cell. A waiting response does not block acceptance;
// the walk only pauses at its end when a new lookup result meets a response
// that is still stalled. Learn requests give no response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_to_mac_cache #(
   parameter int ENTRIES = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  imc_pkg::imc_req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output imc_pkg::imc_rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);

   imc_pkg::imc_scan_type scan      [0:ENTRIES];
   logic [IDX_W-1:0]      match_idx [0:ENTRIES];
   logic [IDX_W-1:0]      free_idx  [0:ENTRIES];

   imc_pkg::imc_scan_type tail;
   imc_pkg::imc_wr_type   wr;
   logic [IDX_W-1:0]      wr_idx;

   logic                  busy_ff, busy_in;
   logic [IDX_W-1:0]      victim_ff, victim_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   imc_pkg::imc_rsp_type  rsp_ff, rsp_in;

   logic req_take;
   logic tail_lookup;
   logic adv;
   logic tail_done;
   logic use_victim;

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;

   // token for the head of the row
   always_comb begin
      scan[0].active    = req_take;
      scan[0].kind      = req_data.kind;
      scan[0].ip_addr   = req_data.ip_addr;
      scan[0].mac_addr  = req_data.mac_addr;
      scan[0].hit       = 1'b0;
      scan[0].found_mac = '0;
      scan[0].free_seen = 1'b0;
   end
   assign match_idx[0] = '0;
   assign free_idx[0]  = '0;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         imc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .adv           (adv),
            .scan_in       (scan[g]),
            .match_idx_in  (match_idx[g]),
            .free_idx_in   (free_idx[g]),
            .scan_out      (scan[g+1]),
            .match_idx_out (match_idx[g+1]),
            .free_idx_out  (free_idx[g+1]),
            .wr            (wr),
            .wr_idx        (wr_idx)
         );
      end
   endgenerate

   assign tail        = scan[ENTRIES];
   assign tail_lookup = tail.active && (tail.kind == imc_pkg::KIND_LOOKUP);
   // hold the row while a lookup result has nowhere to go
   assign adv         = !(tail_lookup && rsp_valid_ff && rsp_stall);
   assign tail_done   = tail.active && adv;
   assign use_victim  = !tail.hit && !tail.free_seen;

   always_comb begin
      wr.en       = tail.active && (tail.kind == imc_pkg::KIND_LEARN);
      wr.ip_addr  = tail.ip_addr;
      wr.mac_addr = tail.mac_addr;
      if (tail.hit) begin
         wr_idx = match_idx[ENTRIES];
      end else if (tail.free_seen) begin
         wr_idx = free_idx[ENTRIES];
      end else begin
         wr_idx = victim_ff;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      victim_in    = victim_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (tail_done) begin
         busy_in = 1'b0;
      end
      if (wr.en && use_victim) begin
         victim_in = (victim_ff == LastIdx) ? '0 : victim_ff + 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (tail_lookup && adv) begin
         rsp_valid_in     = 1'b1;
         rsp_in.hit       = tail.hit;
         rsp_in.found_mac = tail.found_mac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         victim_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         victim_ff    <= victim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4 to MAC cache. A directed sequence covers
// empty misses, extreme keys and MACs, updates, a full fill and the first
// round-robin eviction. A random stream follows. Most of its keys come from a
// small drifting pool so that hits, updates and evictions stay frequent. Every
// accepted request beat goes through a cache model in the bench. Each
// response beat is checked against the oldest predicted lookup result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CacheSlots = 16;
   localparam int PoolSize   = 24;
   localparam int RandBeats  = 1430;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   imc_pkg::imc_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   imc_pkg::imc_rsp_type rsp_data;

   ip_to_mac_cache #(.ENTRIES(CacheSlots)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // bench copy of the cache contents
   bit                           slot_valid [CacheSlots];
   logic [imc_pkg::IpWidth-1:0]  slot_ip    [CacheSlots];
   logic [imc_pkg::MacWidth-1:0] slot_mac   [CacheSlots];
   int                           victim_ptr = 0;

   imc_pkg::imc_req_type pending_beats [$];
   imc_pkg::imc_rsp_type lookup_results [$];

   int fail_count = 0;
   int accepted_count = 0;
   int lookup_count = 0;
   int hit_count = 0;
   int learn_count = 0;
   int evict_count = 0;
   bit all_sent = 1'b0;
   bit idle_on = 1'b1;
   int gap_left = 0;
   int stall_left = 0;

   function automatic imc_pkg::imc_req_type make_beat(
      input logic                         kind,
      input logic [imc_pkg::IpWidth-1:0]  ip,
      input logic [imc_pkg::MacWidth-1:0] mac);
      imc_pkg::imc_req_type beat;
      beat.kind     = kind;
      beat.ip_addr  = ip;
      beat.mac_addr = mac;
      return beat;
   endfunction

   // apply one request beat to the cache copy, queue the lookup result
   task automatic cache_apply(input imc_pkg::imc_req_type beat);
      int                   slot;
      imc_pkg::imc_rsp_type res;
      slot = CacheSlots;
      for (int s = CacheSlots - 1; s >= 0; s--)
         if (slot_valid[s] && slot_ip[s] == beat.ip_addr) slot = s;
      if (beat.kind == imc_pkg::KIND_LEARN) begin
         learn_count++;
         if (slot == CacheSlots) begin
            for (int s = CacheSlots - 1; s >= 0; s--)
               if (!slot_valid[s]) slot = s;
            // all slots busy: take the round-robin victim
            if (slot == CacheSlots) begin
               slot = victim_ptr;
               victim_ptr = (victim_ptr + 1) % CacheSlots;
               evict_count++;
            end
         end
         slot_valid[slot] = 1'b1;
         slot_ip[slot]    = beat.ip_addr;
         slot_mac[slot]   = beat.mac_addr;
      end else begin
         lookup_count++;
         res.hit       = (slot != CacheSlots);
         res.found_mac = res.hit ? slot_mac[slot] : '0;
         if (res.hit) hit_count++;
         lookup_results.push_back(res);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         idle_on = ((accepted_count / 120) % 3 != 2) && (pending_beats.size() > 150);
         if (req_valid && !req_stall) begin
            cache_apply(req_data);
            accepted_count++;
            if (pending_beats.size() == 0) all_sent = 1'b1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      imc_pkg::imc_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lookup_results.size() == 0) begin
               $error("response beat with no lookup pending: hit=%0b found_mac=%h",
                      rsp_data.hit, rsp_data.found_mac);
               fail_count++;
            end else begin
               want = lookup_results.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0b, actual %0b", want.hit, rsp_data.hit);
                  fail_count++;
               end
               if (rsp_data.found_mac !== want.found_mac) begin
                  $error("found_mac: expected %h, actual %h", want.found_mac, rsp_data.found_mac);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [imc_pkg::IpWidth-1:0]  key_pool [PoolSize];
      logic [imc_pkg::IpWidth-1:0]  ip;
      logic [imc_pkg::MacWidth-1:0] mac;
      logic                         kind;

      // empty cache misses, then extreme keys and MACs
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '0, {16'($urandom), $urandom}));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '1, {16'($urandom), $urandom}));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LEARN, '0, '1));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LEARN, '1, '0));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '0, '0));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '1, '1));
      // update in place
      pending_beats.push_back(make_beat(imc_pkg::KIND_LEARN, '0, 48'ha5a5_5a5a_a5a5));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '0, {16'($urandom), $urandom}));
      // fill the rest, then one more learn evicts slot zero
      for (int i = 2; i < CacheSlots; i++)
         pending_beats.push_back(make_beat(imc_pkg::KIND_LEARN, 32'h0a00_0000 + i,
                                           48'h00a0_0000_0000 | 48'(i)));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LEARN, 32'hc0a8_0101,
                                        48'h0123_4567_89ab));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, '0, {16'($urandom), $urandom}));
      pending_beats.push_back(make_beat(imc_pkg::KIND_LOOKUP, 32'hc0a8_0101,
                                        {16'($urandom), $urandom}));

      for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;
      repeat (RandBeats) begin
         // let the key pool drift so old entries age out
         if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, PoolSize - 1)] = $urandom;
         if ($urandom_range(0, 6) == 0) ip = $urandom;
         else ip = key_pool[$urandom_range(0, PoolSize - 1)];
         mac  = {16'($urandom), $urandom};
         kind = ($urandom_range(0, 99) < 45) ? imc_pkg::KIND_LEARN : imc_pkg::KIND_LOOKUP;
         pending_beats.push_back(make_beat(kind, ip, mac));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!all_sent || lookup_results.size() != 0) @(posedge clock);
      repeat (CacheSlots * 3) @(posedge clock);

      $display("covered %0d lookups (%0d hits, %0d misses) and %0d learns",
               lookup_count, hit_count, lookup_count - hit_count, learn_count);
      $display("%0d learns replaced a slot through the round-robin pointer", evict_count);
      if (fail_count == 0 && lookup_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("run timed out");
      $display("status: fail");
      $finish;
   end

endmodule
